// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and defaults for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TICK_WIDTH_DEF  = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLL_TICKS  = 2'd1;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [15:0] POLL_TICKS_RST  = 16'd100;

    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_GCR   = 3'd5;

    localparam logic [7:0] GCR_ADDR_BYTE = 8'h00;
    localparam logic [7:0] GCR_CMD_BYTE  = 8'h06;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] RS_NONE  = 2'd0;
    localparam logic [1:0] RS_ADDR  = 2'd1;
    localparam logic [1:0] RS_CMD   = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_GCR
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S_A, PH_S_B,
        PH_P_A, PH_P_B,
        PH_W_LOW, PH_W_SET, PH_W_HIGH,
        PH_WA_LOW, PH_WA_REL, PH_WA_HIGH, PH_WA_END,
        PH_R_HIGH, PH_R_STR, PH_R_SAMP, PH_R_LOW,
        PH_RA_WAIT, PH_RA_DRV, PH_RA_HIGH, PH_RA_END
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic [7:0] stretch_limit;
        logic       sda_in;
        logic       scl_in;
    } in_beat_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [1:0] status;
    } out_beat_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic [7:0] stretch_limit;
        logic       sda_in;
        logic       scl_in;
    } tick_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] stretch_poll_ticks;
    } cfg_t;

endpackage

// ===== design/i2cm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input beats, decodes the action field and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  i2cm_pkg::in_beat_t in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output i2cm_pkg::tick_t    q_data
);

    i2cm_pkg::tick_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            push;
    logic            pop;
    i2cm_pkg::tick_t entry;

    always_comb
    begin
        entry.tx_byte       = in_data.tx_byte;
        entry.send_ack      = in_data.send_ack;
        entry.stretch_limit = in_data.stretch_limit;
        entry.sda_in        = in_data.sda_in;
        entry.scl_in        = in_data.scl_in;
        case (in_data.action)
            i2cm_pkg::ACT_START: entry.cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::ACT_STOP:  entry.cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::ACT_WRITE: entry.cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::ACT_READ:  entry.cmd = i2cm_pkg::CMD_READ;
            i2cm_pkg::ACT_GCR:   entry.cmd = i2cm_pkg::CMD_GCR;
            default:             entry.cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    assign q_data = mem_reg[rd_ptr_reg];

endmodule

// ===== design/i2cm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: steps the I2C phase machine once per queued tick and
// registers one result beat per tick.
// ----------------------------------------------------------------------------
module i2cm_engine
#(
    parameter int TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2cm_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  i2cm_pkg::tick_t     q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cm_pkg::out_beat_t out_data
);

    localparam int LEN_WIDTH = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    i2cm_pkg::phase_t    phase_reg;
    i2cm_pkg::phase_t    phase_next;
    logic [3:0]          bit_reg;
    logic [3:0]          bit_next;
    logic [7:0]          shift_reg;
    logic [7:0]          shift_next;
    logic [TICK_WIDTH-1:0] tick_reg;
    logic [TICK_WIDTH-1:0] tick_next;
    logic [15:0]         poll_reg;
    logic [15:0]         poll_next;
    logic [7:0]          left_reg;
    logic [7:0]          left_next;
    logic [1:0]          err_reg;
    logic [1:0]          err_next;
    logic [1:0]          rs_reg;
    logic [1:0]          rs_next;
    logic                ack_reg;
    logic                ack_next;
    logic [7:0]          limit_reg;
    logic [7:0]          limit_next;
    logic [7:0]          rx_reg;
    logic [7:0]          rx_next;
    logic                scl_drv_reg;
    logic                scl_drv_next;
    logic                sda_drv_reg;
    logic                sda_drv_next;
    logic                done_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    i2cm_pkg::out_beat_t out_data_reg;
    i2cm_pkg::out_beat_t out_data_next;

    logic                fire;
    logic [LEN_WIDTH-1:0] len_ext;
    logic [LEN_WIDTH-1:0] mask_ext;
    logic [TICK_WIDTH-1:0] step_len;
    logic [TICK_WIDTH-1:0] tick_inc;
    logic [15:0]         poll_len;

    assign q_ready = !out_valid_reg || out_ready;
    assign fire    = q_valid && q_ready;

    always_comb
    begin
        mask_ext = LEN_WIDTH'({TICK_WIDTH{1'b1}});
        len_ext  = LEN_WIDTH'(cfg.phase_ticks);
        if (len_ext == '0)
        begin
            len_ext = LEN_WIDTH'(1);
        end
        else if (len_ext > mask_ext)
        begin
            len_ext = mask_ext;
        end
        step_len = len_ext[TICK_WIDTH-1:0];
        tick_inc = tick_reg + TICK_WIDTH'(1);
        poll_len = (cfg.stretch_poll_ticks == 16'd0) ? 16'd0
                                                     : cfg.stretch_poll_ticks - 16'd1;
    end

    // next state and datapath
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        poll_next  = poll_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        rs_next    = rs_reg;
        ack_next   = ack_reg;
        limit_next = limit_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        if (fire)
        begin
            case (phase_reg)
                i2cm_pkg::PH_IDLE:
                begin
                    if (q_data.cmd != i2cm_pkg::CMD_NONE)
                    begin
                        err_next   = i2cm_pkg::ST_OK;
                        rs_next    = i2cm_pkg::RS_NONE;
                        ack_next   = q_data.send_ack;
                        limit_next = q_data.stretch_limit;
                        bit_next   = 4'd0;
                        tick_next  = '0;
                        case (q_data.cmd)
                            i2cm_pkg::CMD_START: phase_next = i2cm_pkg::PH_S_A;
                            i2cm_pkg::CMD_STOP:  phase_next = i2cm_pkg::PH_P_A;
                            i2cm_pkg::CMD_WRITE:
                            begin
                                shift_next = q_data.tx_byte;
                                phase_next = i2cm_pkg::PH_W_LOW;
                            end
                            i2cm_pkg::CMD_READ:
                            begin
                                shift_next = 8'd0;
                                phase_next = i2cm_pkg::PH_R_HIGH;
                            end
                            default:
                            begin
                                rs_next    = i2cm_pkg::RS_ADDR;
                                phase_next = i2cm_pkg::PH_S_A;
                            end
                        endcase
                    end
                end
                i2cm_pkg::PH_R_STR:
                begin
                    if (poll_reg != 16'd0)
                    begin
                        poll_next = poll_reg - 16'd1;
                    end
                    else if (q_data.scl_in)
                    begin
                        tick_next  = '0;
                        phase_next = i2cm_pkg::PH_R_SAMP;
                    end
                    else if (left_reg == 8'd0)
                    begin
                        if (err_reg == i2cm_pkg::ST_OK)
                        begin
                            err_next = i2cm_pkg::ST_TIMEOUT;
                        end
                        tick_next  = '0;
                        phase_next = i2cm_pkg::PH_R_SAMP;
                    end
                    else
                    begin
                        left_next = left_reg - 8'd1;
                        poll_next = poll_len;
                    end
                end
                default:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= step_len)
                    begin
                        tick_next = '0;
                        case (phase_reg)
                            i2cm_pkg::PH_S_A: phase_next = i2cm_pkg::PH_S_B;
                            i2cm_pkg::PH_S_B:
                            begin
                                if (rs_reg == i2cm_pkg::RS_ADDR)
                                begin
                                    shift_next = i2cm_pkg::GCR_ADDR_BYTE;
                                    bit_next   = 4'd0;
                                    phase_next = i2cm_pkg::PH_W_LOW;
                                end
                                else
                                begin
                                    rs_next    = i2cm_pkg::RS_NONE;
                                    done_next  = 1'b1;
                                    phase_next = i2cm_pkg::PH_IDLE;
                                end
                            end
                            i2cm_pkg::PH_P_A: phase_next = i2cm_pkg::PH_P_B;
                            i2cm_pkg::PH_W_LOW: phase_next = i2cm_pkg::PH_W_SET;
                            i2cm_pkg::PH_W_SET: phase_next = i2cm_pkg::PH_W_HIGH;
                            i2cm_pkg::PH_W_HIGH:
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bit_next   = bit_reg + 4'd1;
                                phase_next = bit_next[3] ? i2cm_pkg::PH_WA_LOW
                                                         : i2cm_pkg::PH_W_LOW;
                            end
                            i2cm_pkg::PH_WA_LOW: phase_next = i2cm_pkg::PH_WA_REL;
                            i2cm_pkg::PH_WA_REL: phase_next = i2cm_pkg::PH_WA_HIGH;
                            i2cm_pkg::PH_WA_HIGH:
                            begin
                                if (q_data.sda_in && err_reg == i2cm_pkg::ST_OK)
                                begin
                                    err_next = i2cm_pkg::ST_NACK;
                                end
                                phase_next = i2cm_pkg::PH_WA_END;
                            end
                            i2cm_pkg::PH_WA_END:
                            begin
                                if (rs_reg == i2cm_pkg::RS_ADDR && err_reg == i2cm_pkg::ST_OK)
                                begin
                                    rs_next    = i2cm_pkg::RS_CMD;
                                    shift_next = i2cm_pkg::GCR_CMD_BYTE;
                                    bit_next   = 4'd0;
                                    phase_next = i2cm_pkg::PH_W_LOW;
                                end
                                else
                                begin
                                    rs_next    = i2cm_pkg::RS_NONE;
                                    done_next  = 1'b1;
                                    phase_next = i2cm_pkg::PH_IDLE;
                                end
                            end
                            i2cm_pkg::PH_R_HIGH:
                            begin
                                poll_next  = 16'd0;
                                left_next  = limit_reg;
                                phase_next = i2cm_pkg::PH_R_STR;
                            end
                            i2cm_pkg::PH_R_SAMP:
                            begin
                                shift_next = {shift_reg[6:0], q_data.sda_in};
                                phase_next = i2cm_pkg::PH_R_LOW;
                            end
                            i2cm_pkg::PH_R_LOW:
                            begin
                                bit_next   = bit_reg + 4'd1;
                                phase_next = bit_next[3] ? i2cm_pkg::PH_RA_WAIT
                                                         : i2cm_pkg::PH_R_HIGH;
                            end
                            i2cm_pkg::PH_RA_WAIT: phase_next = i2cm_pkg::PH_RA_DRV;
                            i2cm_pkg::PH_RA_DRV:  phase_next = i2cm_pkg::PH_RA_HIGH;
                            i2cm_pkg::PH_RA_HIGH: phase_next = i2cm_pkg::PH_RA_END;
                            i2cm_pkg::PH_RA_END:
                            begin
                                rx_next    = shift_reg;
                                rs_next    = i2cm_pkg::RS_NONE;
                                done_next  = 1'b1;
                                phase_next = i2cm_pkg::PH_IDLE;
                            end
                            default:
                            begin
                                rs_next    = i2cm_pkg::RS_NONE;
                                done_next  = 1'b1;
                                phase_next = i2cm_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // line drive on phase entry and result beat
    always_comb
    begin
        scl_drv_next = scl_drv_reg;
        sda_drv_next = sda_drv_reg;
        if (fire && phase_next != phase_reg)
        begin
            case (phase_next)
                i2cm_pkg::PH_S_A:
                begin
                    scl_drv_next = 1'b0;
                    sda_drv_next = 1'b0;
                end
                i2cm_pkg::PH_S_B:     sda_drv_next = 1'b1;
                i2cm_pkg::PH_P_A:
                begin
                    scl_drv_next = 1'b0;
                    sda_drv_next = 1'b1;
                end
                i2cm_pkg::PH_P_B:     sda_drv_next = 1'b0;
                i2cm_pkg::PH_W_LOW:   scl_drv_next = 1'b1;
                i2cm_pkg::PH_W_SET:   sda_drv_next = ~shift_next[7];
                i2cm_pkg::PH_W_HIGH:  scl_drv_next = 1'b0;
                i2cm_pkg::PH_WA_LOW:  scl_drv_next = 1'b1;
                i2cm_pkg::PH_WA_REL:  sda_drv_next = 1'b0;
                i2cm_pkg::PH_WA_HIGH: scl_drv_next = 1'b0;
                i2cm_pkg::PH_WA_END:  scl_drv_next = 1'b1;
                i2cm_pkg::PH_R_HIGH:
                begin
                    scl_drv_next = 1'b0;
                    sda_drv_next = 1'b0;
                end
                i2cm_pkg::PH_R_LOW:   scl_drv_next = 1'b1;
                i2cm_pkg::PH_RA_DRV:  sda_drv_next = ack_reg;
                i2cm_pkg::PH_RA_HIGH: scl_drv_next = 1'b0;
                i2cm_pkg::PH_RA_END:
                begin
                    scl_drv_next = 1'b1;
                    sda_drv_next = 1'b0;
                end
                default:
                begin
                    scl_drv_next = scl_drv_reg;
                    sda_drv_next = sda_drv_reg;
                end
            endcase
        end

        out_data_next.scl_low  = scl_drv_next;
        out_data_next.sda_low  = sda_drv_next;
        out_data_next.busy_res = (phase_next != i2cm_pkg::PH_IDLE);
        out_data_next.done_res = done_next;
        out_data_next.rx_byte  = rx_next;
        out_data_next.status   = err_next;

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= '0;
            poll_reg      <= 16'd0;
            left_reg      <= 8'd0;
            err_reg       <= i2cm_pkg::ST_OK;
            rs_reg        <= i2cm_pkg::RS_NONE;
            ack_reg       <= 1'b0;
            limit_reg     <= 8'd0;
            rx_reg        <= 8'd0;
            scl_drv_reg   <= 1'b0;
            sda_drv_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            poll_reg      <= poll_next;
            left_reg      <= left_next;
            err_reg       <= err_next;
            rs_reg        <= rs_next;
            ack_reg       <= ack_next;
            limit_reg     <= limit_next;
            rx_reg        <= rx_next;
            scl_drv_reg   <= scl_drv_next;
            sda_drv_reg   <= sda_drv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine: start, stop, write, read and general call reset,
// one input beat per bus tick, one result beat per input beat.
//
//   channel   direction   handshake              beat
//   in        input       in_valid / in_ready    in_data   (in_beat_t)
//   out       output      out_valid / out_ready  out_data  (out_beat_t)
//   cfg       input       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready holds; each beat passes through
// the two-entry tick queue, then the phase sequencer, which loads the result
// register. Reset clears the queue, the sequencer and the configuration
// (phase ticks 10, poll ticks 100). A stalled output holds the sequencer; the
// queue keeps accepting until full. Config writes never stall.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
#(
    parameter int TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  i2cm_pkg::in_beat_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output i2cm_pkg::out_beat_t                    out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    i2cm_pkg::cfg_t  cfg_reg;
    i2cm_pkg::cfg_t  cfg_next;
    logic            q_valid;
    logic            q_ready;
    i2cm_pkg::tick_t q_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_PHASE_TICKS: cfg_next.phase_ticks        = cfg_data;
                i2cm_pkg::CFG_POLL_TICKS:  cfg_next.stretch_poll_ticks = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks        <= i2cm_pkg::PHASE_TICKS_RST;
            cfg_reg.stretch_poll_ticks <= i2cm_pkg::POLL_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    i2cm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    i2cm_engine #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done beat still reports busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= i2cm_pkg::ST_TIMEOUT)
        else $error("status carries an undefined code");

    a_beat_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> q_valid || out_valid)
        else $error("accepted beat lost between queue and result register");

endmodule
